FILE: rtl/mncq_pkg.sv
package mncq_pkg;

   localparam int PITCH_COUNT    = 128;
   localparam int PITCH_BITS     = $clog2(PITCH_COUNT);
   localparam int NOTE_BITS      = 7;
   localparam int VEL_BITS       = 7;
   localparam int TICK_BITS      = 32;
   localparam int GRID_BITS      = 16;
   localparam int MIN_NOTE_TICKS = 60;
   localparam int STEP_BITS      = $clog2(TICK_BITS);
   localparam int ENTRY_BITS     = TICK_BITS + VEL_BITS;
   localparam int CSR_IDX_BITS   = 2;
   localparam int CSR_DATA_BITS  = GRID_BITS;

   localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

   // event codes
   localparam logic [1:0] FUNC_NOTE_ON  = 2'd0;
   localparam logic [1:0] FUNC_NOTE_OFF = 2'd1;
   localparam logic [1:0] FUNC_START    = 2'd2;
   localparam logic [1:0] FUNC_STOP     = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_QUANT_EN = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRID     = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REPLACE  = 2'd2;

   typedef struct packed {
      logic load;
      logic start_rec;
      logic stop_rec;
      logic div_init;
      logic div_step;
      logic snap_load;
      logic entry_write;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       recording;
      logic       in_range;
      logic       hit;
      logic       out_busy;
   } status_type;

endpackage

FILE: rtl/mncq_req_if.sv
interface mncq_req_if;
   import mncq_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [1:0]            func;
   logic [NOTE_BITS-1:0]  note_number;
   logic [VEL_BITS-1:0]   note_velocity;
   logic [TICK_BITS-1:0]  event_tick;

   modport source (output valid, func, note_number, note_velocity, event_tick,
                   input ready);
   modport sink (input valid, func, note_number, note_velocity, event_tick,
                 output ready);
endinterface

FILE: rtl/mncq_rsp_if.sv
interface mncq_rsp_if;
   import mncq_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [NOTE_BITS-1:0]  out_pitch;
   logic [TICK_BITS-1:0]  out_start_tick;
   logic [TICK_BITS-1:0]  out_end_tick;
   logic [VEL_BITS-1:0]   out_velocity;
   logic                  replace_first;

   modport source (output valid, out_pitch, out_start_tick, out_end_tick,
                   out_velocity, replace_first, input ready);
   modport sink (input valid, out_pitch, out_start_tick, out_end_tick,
                 out_velocity, replace_first, output ready);
endinterface

FILE: rtl/mncq_ctrl.sv
module mncq_ctrl
   import mncq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_DIVIDE = 3'd2;
   localparam logic [2:0] ST_SNAP   = 3'd3;
   localparam logic [2:0] ST_WRITE  = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;

   assign in_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.func == FUNC_START) begin
               cmd.start_rec = 1'b1;
               state_in      = ST_IDLE;
            end else if (status.func == FUNC_STOP) begin
               cmd.stop_rec = 1'b1;
               state_in     = ST_IDLE;
            end else if (!status.recording || !status.in_range) begin
               state_in = ST_IDLE;
            end else if (status.func == FUNC_NOTE_OFF && !status.hit) begin
               state_in = ST_IDLE;
            end else begin
               cmd.div_init = 1'b1;
               step_in      = '0;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(TICK_BITS - 1)) begin
               state_in = ST_SNAP;
            end
         end
         ST_SNAP: begin
            cmd.snap_load = 1'b1;
            state_in      = (status.func == FUNC_NOTE_ON) ? ST_WRITE : ST_EMIT;
         end
         ST_WRITE: begin
            cmd.entry_write = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
   end

endmodule

FILE: rtl/mncq_dp.sv
module mncq_dp
   import mncq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic [1:0]               in_func,
   input  logic [NOTE_BITS-1:0]     in_note,
   input  logic [VEL_BITS-1:0]      in_vel,
   input  logic [TICK_BITS-1:0]     in_tick,
   input  cmd_type                  cmd,
   output status_type               status,
   mncq_rsp_if.source               rsp_ch
);

   // configuration
   logic                 quant_en_ff;
   logic [GRID_BITS-1:0] grid_ff;
   logic                 replace_ff;

   // captured item
   logic [1:0]           func_ff;
   logic [NOTE_BITS-1:0] pitch_ff;
   logic [VEL_BITS-1:0]  vel_ff;
   logic [TICK_BITS-1:0] tick_ff;

   // remainder unit
   logic [TICK_BITS-1:0] shift_ff;
   logic [GRID_BITS-1:0] rem_ff;
   logic [GRID_BITS:0]   rem_sh;
   logic [GRID_BITS-1:0] rem_in;

   // snapping
   logic [TICK_BITS-1:0] snap_ff, snap_in;
   logic [TICK_BITS:0]   up_sum;

   // open notes
   logic                    recording_ff;
   logic [PITCH_COUNT-1:0]  open_valid_ff;
   logic [ENTRY_BITS-1:0]   entry_mem [PITCH_COUNT];
   logic [ENTRY_BITS-1:0]   rd_data_ff;
   logic [PITCH_BITS-1:0]   idx;

   // result
   logic [TICK_BITS-1:0] held_start;
   logic [VEL_BITS-1:0]  held_vel;
   logic [TICK_BITS:0]   min_sum;
   logic [TICK_BITS-1:0] end_in;
   logic                 rsp_valid_ff;
   logic [NOTE_BITS-1:0] out_pitch_ff;
   logic [TICK_BITS-1:0] out_start_ff;
   logic [TICK_BITS-1:0] out_end_ff;
   logic [VEL_BITS-1:0]  out_vel_ff;
   logic                 out_repl_ff;

   assign idx = pitch_ff[PITCH_BITS-1:0];

   assign status.func      = func_ff;
   assign status.recording = recording_ff;
   assign status.in_range  = ({1'b0, pitch_ff} < (NOTE_BITS + 1)'(PITCH_COUNT));
   assign status.hit       = open_valid_ff[idx];
   assign status.out_busy  = rsp_valid_ff && !rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         quant_en_ff <= 1'b0;
         grid_ff     <= '0;
         replace_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_QUANT_EN: quant_en_ff <= csr_wdata[0];
            CSR_GRID:     grid_ff     <= csr_wdata[GRID_BITS-1:0];
            CSR_REPLACE:  replace_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= in_func;
         pitch_ff <= in_note;
         vel_ff   <= in_vel;
         tick_ff  <= in_tick;
      end
   end

   // restoring remainder, one tick bit per cycle, msb first
   always_comb begin
      rem_sh = {rem_ff, shift_ff[TICK_BITS-1]};
      if (rem_sh >= {1'b0, grid_ff}) begin
         rem_in = GRID_BITS'(rem_sh - {1'b0, grid_ff});
      end else begin
         rem_in = rem_sh[GRID_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         shift_ff <= tick_ff;
         rem_ff   <= '0;
      end else if (cmd.div_step) begin
         shift_ff <= {shift_ff[TICK_BITS-2:0], 1'b0};
         rem_ff   <= rem_in;
      end
   end

   // round down below half the grid, else up; saturating
   always_comb begin
      up_sum = {1'b0, tick_ff} + (TICK_BITS + 1)'(grid_ff - rem_ff);
      if (!quant_en_ff || grid_ff == '0) begin
         snap_in = tick_ff;
      end else if (rem_ff < (grid_ff >> 1)) begin
         snap_in = tick_ff - TICK_BITS'(rem_ff);
      end else if (up_sum[TICK_BITS]) begin
         snap_in = TICK_MAX;
      end else begin
         snap_in = up_sum[TICK_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.snap_load) begin
         snap_ff <= snap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.entry_write) begin
         entry_mem[idx] <= {snap_ff, vel_ff};
      end
      rd_data_ff <= entry_mem[idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recording_ff  <= 1'b0;
         open_valid_ff <= '0;
      end else begin
         if (cmd.start_rec || cmd.stop_rec) begin
            recording_ff  <= cmd.start_rec;
            open_valid_ff <= '0;
         end else if (cmd.entry_write) begin
            open_valid_ff[idx] <= 1'b1;
         end else if (cmd.emit) begin
            open_valid_ff[idx] <= 1'b0;
         end
      end
   end

   // notes not ending after start get the minimum length
   assign held_start = rd_data_ff[ENTRY_BITS-1:VEL_BITS];
   assign held_vel   = rd_data_ff[VEL_BITS-1:0];
   assign min_sum    = {1'b0, held_start} + (TICK_BITS + 1)'(MIN_NOTE_TICKS);

   always_comb begin
      if (snap_ff > held_start) begin
         end_in = snap_ff;
      end else if (min_sum[TICK_BITS]) begin
         end_in = TICK_MAX;
      end else begin
         end_in = min_sum[TICK_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_pitch_ff <= pitch_ff;
         out_start_ff <= held_start;
         out_end_ff   <= end_in;
         out_vel_ff   <= held_vel;
         out_repl_ff  <= replace_ff;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.out_pitch      = out_pitch_ff;
   assign rsp_ch.out_start_tick = out_start_ff;
   assign rsp_ch.out_end_tick   = out_end_ff;
   assign rsp_ch.out_velocity   = out_vel_ff;
   assign rsp_ch.replace_first  = out_repl_ff;

endmodule

FILE: rtl/midi_note_capture_quantizer.sv
// a note-off result is valid after the decode, divide, snap and emit states (+ wait while
//   the result register is full); a new item is taken only in idle, after the last is done;
//   the grid remainder takes one tick bit per cycle (32 steps for a 32-bit tick)
// a finished result waits in the output register while the next item is taken
// reset (synchronous, active high) clears configuration, recording, open notes and output valid
module midi_note_capture_quantizer
   import mncq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   mncq_req_if.sink                 req_ch,
   mncq_rsp_if.source               rsp_ch
);

   cmd_type    cmd;
   status_type status;
   logic       in_ready;

   assign req_ch.ready = in_ready;

   mncq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_ready (in_ready),
      .status   (status),
      .cmd      (cmd)
   );

   mncq_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_func   (req_ch.func),
      .in_note   (req_ch.note_number),
      .in_vel    (req_ch.note_velocity),
      .in_tick   (req_ch.event_tick),
      .cmd       (cmd),
      .status    (status),
      .rsp_ch    (rsp_ch)
   );

endmodule
